// ----- design/cbs_pkg.sv -----
package cbs_pkg;

    localparam int WEIGHT_W   = 18;
    localparam int FRAC_W     = 16;
    localparam int ROUND_HALF = 32768;
    localparam int TERMS      = 4;
    localparam int SEQ_STEPS  = 2 * TERMS;
    localparam int STEP_W     = 4;

    typedef logic [WEIGHT_W-1:0] weight_t;

    typedef struct packed {
        logic issue;
        logic first;
        logic sel_y;
    } mac_ctl_t;

endpackage

// ----- design/cbs_point_if.sv -----
interface cbs_point_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         start_curve;
    logic signed [COORD_BITS-1:0] ctrl_x;
    logic signed [COORD_BITS-1:0] ctrl_y;

    modport source (output valid, start_curve, ctrl_x, ctrl_y, input ready);
    modport sink (input valid, start_curve, ctrl_x, ctrl_y, output ready);
endinterface

// ----- design/cbs_sample_if.sv -----
interface cbs_sample_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] curve_x;
    logic signed [COORD_BITS-1:0] curve_y;
    logic                         last_sample;

    modport source (output valid, curve_x, curve_y, last_sample, input ready);
    modport sink (input valid, curve_x, curve_y, last_sample, output ready);
endinterface

// ----- design/cubic_bspline_curve_sampler_unit.sv -----
// Uniform cubic B-spline sampler. Control points (signed Q8.8) come in one beat at a time;
// the first three of a curve (and any beat with start_curve set, which begins a new curve)
// are only stored while ready stays high. Every further point closes a segment with the
// three before it and yields SAMPLES_PER_SEGMENT samples at u = k/SAMPLES_PER_SEGMENT, the
// last one flagged by last_sample. Each sample is computed on the single shared
// multiply-accumulate unit (4 weights times 2 coordinates, plus pipeline fill and the hand-off
// to the output register), and a sample waits in that register while the sink stalls. Point
// ready is low while a segment is computed. Results are rounded half up and saturated to
// COORD_BITS.
module cubic_bspline_curve_sampler_unit #(
    parameter int SAMPLES_PER_SEGMENT = 5,
    parameter int COORD_BITS          = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    cbs_point_if.sink    point,
    cbs_sample_if.source sample
);
    localparam int KW = (SAMPLES_PER_SEGMENT > 1) ? $clog2(SAMPLES_PER_SEGMENT) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(SAMPLES_PER_SEGMENT - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [cbs_pkg::STEP_W-1:0] STEP_END = cbs_pkg::STEP_W'(cbs_pkg::SEQ_STEPS);

    cbs_pkg::weight_t w_tab [SAMPLES_PER_SEGMENT][cbs_pkg::TERMS];

    for (genvar gk = 0; gk < SAMPLES_PER_SEGMENT; gk++)
    begin : g_wt
        localparam longint S   = SAMPLES_PER_SEGMENT;
        localparam longint T   = gk;
        localparam longint R   = S - T;
        localparam longint DEN = 6 * S * S * S;
        localparam longint N0  = R * R * R;
        localparam longint N1  = 3 * T * T * T - 6 * T * T * S + 4 * S * S * S;
        localparam longint N2  = -3 * T * T * T + 3 * T * T * S + 3 * T * S * S + S * S * S;
        localparam longint N3  = T * T * T;
        localparam longint W0  = (N0 * 65536 + DEN / 2) / DEN;
        localparam longint W1  = (N1 * 65536 + DEN / 2) / DEN;
        localparam longint W2  = (N2 * 65536 + DEN / 2) / DEN;
        localparam longint W3  = (N3 * 65536 + DEN / 2) / DEN;
        assign w_tab[gk][0] = cbs_pkg::WEIGHT_W'(W0);
        assign w_tab[gk][1] = cbs_pkg::WEIGHT_W'(W1);
        assign w_tab[gk][2] = cbs_pkg::WEIGHT_W'(W2);
        assign w_tab[gk][3] = cbs_pkg::WEIGHT_W'(W3);
    end

    logic [1:0]                     state_reg, state_next;
    logic [1:0]                     held_reg, held_next;
    logic [KW-1:0]                  k_reg, k_next;
    logic [cbs_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                           out_valid_reg, out_valid_next;

    logic signed [COORD_BITS-1:0]   win_x_reg [3];
    logic signed [COORD_BITS-1:0]   win_y_reg [3];
    logic signed [COORD_BITS-1:0]   px_reg, py_reg;
    logic signed [COORD_BITS-1:0]   out_x_reg, out_y_reg;
    logic                           out_last_reg;

    logic                           accept;
    logic                           fill;
    logic [1:0]                     fill_idx;
    logic                           out_load;
    logic                           seg_done;
    logic [1:0]                     term;
    logic                           sel_y;
    logic signed [COORD_BITS-1:0]   op;
    cbs_pkg::mac_ctl_t              ctl;
    logic signed [COORD_BITS-1:0]   res_x, res_y;

    assign point.ready = (state_reg == ST_IDLE);
    assign accept      = point.valid && point.ready;
    assign fill        = point.start_curve || (held_reg != 2'd3);
    assign fill_idx    = point.start_curve ? 2'd0 : held_reg;

    assign term     = step_reg[1:0];
    assign sel_y    = step_reg[2];
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || sample.ready);
    assign seg_done = out_load && (k_reg == K_LAST);

    always_comb
    begin
        if (term == 2'd3)
            op = sel_y ? py_reg : px_reg;
        else
            op = sel_y ? win_y_reg[term] : win_x_reg[term];
    end

    always_comb
    begin
        ctl.issue = (state_reg == ST_CALC) && (step_reg != STEP_END);
        ctl.first = (term == 2'd0);
        ctl.sel_y = sel_y;
    end

    cbs_mac #(
        .COORD_BITS(COORD_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .op    (op),
        .wt    (w_tab[k_reg][term]),
        .res_x (res_x),
        .res_y (res_y)
    );

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && sample.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (fill)
                    begin
                        held_next = fill_idx + 2'd1;
                    end
                    else
                    begin
                        state_next = ST_CALC;
                        k_next     = '0;
                        step_next  = '0;
                    end
                end
            end
            ST_CALC:
            begin
                if (step_reg == STEP_END)
                    state_next = ST_EMIT;
                else
                    step_next = step_reg + cbs_pkg::STEP_W'(1);
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    step_next      = '0;
                    if (seg_done)
                    begin
                        state_next = ST_IDLE;
                        k_next     = '0;
                    end
                    else
                    begin
                        state_next = ST_CALC;
                        k_next     = k_reg + KW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= 2'd0;
            k_reg         <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            k_reg         <= k_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // point window and output beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (fill)
            begin
                win_x_reg[fill_idx] <= point.ctrl_x;
                win_y_reg[fill_idx] <= point.ctrl_y;
            end
            else
            begin
                px_reg <= point.ctrl_x;
                py_reg <= point.ctrl_y;
            end
        end
        if (seg_done)
        begin
            win_x_reg[0] <= win_x_reg[1];
            win_x_reg[1] <= win_x_reg[2];
            win_x_reg[2] <= px_reg;
            win_y_reg[0] <= win_y_reg[1];
            win_y_reg[1] <= win_y_reg[2];
            win_y_reg[2] <= py_reg;
        end
        if (out_load)
        begin
            out_x_reg    <= res_x;
            out_y_reg    <= res_y;
            out_last_reg <= (k_reg == K_LAST);
        end
    end

    assign sample.valid       = out_valid_reg;
    assign sample.curve_x     = out_x_reg;
    assign sample.curve_y     = out_y_reg;
    assign sample.last_sample = out_last_reg;

endmodule

// ----- design/cbs_mac.sv -----
module cbs_mac #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cbs_pkg::mac_ctl_t            ctl,
    input  logic signed [COORD_BITS-1:0] op,
    input  cbs_pkg::weight_t             wt,
    output logic signed [COORD_BITS-1:0] res_x,
    output logic signed [COORD_BITS-1:0] res_y
);
    localparam int ACC_W  = COORD_BITS + cbs_pkg::WEIGHT_W;
    localparam int FULL_W = COORD_BITS + cbs_pkg::WEIGHT_W + 1;
    localparam int QW     = ACC_W + 1;
    localparam logic signed [QW-1:0] SAT_HI = QW'((longint'(1) <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [QW-1:0] SAT_LO = -SAT_HI - QW'(1);

    logic signed [FULL_W-1:0] full;
    logic signed [ACC_W-1:0]  prod_reg;
    logic                     prod_valid_reg;
    logic                     prod_first_reg;
    logic                     prod_y_reg;
    logic signed [ACC_W-1:0]  acc_x_reg;
    logic signed [ACC_W-1:0]  acc_y_reg;

    function automatic logic signed [COORD_BITS-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [QW-1:0] q;
        logic signed [QW-1:0] r;
        q = {a[ACC_W-1], a} + QW'(cbs_pkg::ROUND_HALF);
        r = q >>> cbs_pkg::FRAC_W;
        if (r > SAT_HI)
            return {1'b0, {(COORD_BITS-1){1'b1}}};
        else if (r < SAT_LO)
            return {1'b1, {(COORD_BITS-1){1'b0}}};
        else
            return r[COORD_BITS-1:0];
    endfunction

    assign full = op * signed'({1'b0, wt});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctl.issue;
        end
    end

    // product stage, then accumulate
    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            prod_reg       <= full[ACC_W-1:0];
            prod_first_reg <= ctl.first;
            prod_y_reg     <= ctl.sel_y;
        end
        if (prod_valid_reg)
        begin
            if (prod_y_reg)
                acc_y_reg <= prod_first_reg ? prod_reg : acc_y_reg + prod_reg;
            else
                acc_x_reg <= prod_first_reg ? prod_reg : acc_x_reg + prod_reg;
        end
    end

    assign res_x = round_sat(acc_x_reg);
    assign res_y = round_sat(acc_y_reg);

endmodule

// ----- design/cbs_chk.sv -----
module cbs_chk #(
    parameter int COORD_BITS = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  point_ready,
    input logic                  sample_valid,
    input logic                  sample_ready,
    input logic [COORD_BITS-1:0] sample_x,
    input logic [COORD_BITS-1:0] sample_y,
    input logic                  sample_last
);
    // stalled beat stays up
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> sample_valid)
        else $error("sample beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=>
            $stable(sample_x) && $stable(sample_y) && $stable(sample_last))
        else $error("sample payload changed while stalled");

    // mid-segment sample means the block is busy
    a_busy_mid_segment: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_last |-> !point_ready)
        else $error("point ready while a segment is unfinished");

    // an idle block cannot raise a sample in the next cycle
    a_no_sample_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        point_ready && !sample_valid |=> !sample_valid)
        else $error("sample appeared directly out of idle");

endmodule

bind cubic_bspline_curve_sampler_unit cbs_chk #(
    .COORD_BITS(COORD_BITS)
) u_cbs_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_ready  (point.ready),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .sample_x     (sample.curve_x),
    .sample_y     (sample.curve_y),
    .sample_last  (sample.last_sample)
);
